// ===== design/addressed_frame_receiver_top_macros.svh =====
// Assertion macros for the addressed frame receiver.
// Included by the top level; assertions compile away when SYNTH is defined.
`ifndef ADDRESSED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define AFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afr assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define AFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afr assertion failed");
`else
`define AFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define AFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/afr_pkg.sv =====
// Shared types and constants for the addressed frame receiver.
// No dependencies; imported by every module of the block.
package afr_pkg;

  // Largest payload a frame may carry; longer declared lengths are clamped.
  localparam int unsigned PayloadMax = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 3;
  localparam int unsigned OutDataW   = 56;
  localparam logic [LenW-1:0] LenMax = LenW'(PayloadMax);

  // Register reset values.
  localparam logic [ByteW-1:0] TimeoutReset = 8'd20;
  localparam logic [ByteW-1:0] OwnAddrReset = 8'd0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SRC,
    PH_LEN,
    PH_PAY
  } afr_phase_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_DROPPED     = 2'd1,
    ST_HDR_TIMEOUT = 2'd2,
    ST_PAY_TIMEOUT = 2'd3
  } afr_status_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } afr_action_e;

  typedef enum logic {
    REG_TIMEOUT  = 1'b0,
    REG_OWN_ADDR = 1'b1
  } afr_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] timeout_ticks;
    logic [ByteW-1:0] own_address;
  } afr_cfg_t;

  typedef struct packed {
    afr_action_e      action;
    logic [ByteW-1:0] byte_value;
  } afr_item_t;

  typedef struct packed {
    afr_status_e                       status;
    logic [ByteW-1:0]                  source;
    logic [LenW-1:0]                   length;
    logic [PayloadMax-1:0][ByteW-1:0]  payload;
  } afr_result_t;

endpackage

// ===== design/afr_cfg_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on afr_pkg for the register index codes and the config struct.
module afr_cfg_regs import afr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output afr_cfg_t    cfg_o
);

  afr_cfg_t cfg_q;
  afr_reg_e reg_sel;
  logic     wr_en;

  // Word-aligned decode: bit 2 picks the register, the low bits are byte lanes.
  assign reg_sel = afr_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TimeoutReset;
      cfg_q.own_address   <= OwnAddrReset;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TIMEOUT:  cfg_q.timeout_ticks <= pwdata[ByteW-1:0];
        REG_OWN_ADDR: cfg_q.own_address   <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; misaligned addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_sel)
        REG_TIMEOUT:  prdata = {24'd0, cfg_q.timeout_ticks};
        REG_OWN_ADDR: prdata = {24'd0, cfg_q.own_address};
        default:      prdata = '0;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/afr_in_reg.sv =====
// Input register stage for received bytes and ticks.
// Depends on afr_pkg for the input item struct.
module afr_in_reg import afr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  afr_item_t s_item_i,
  output logic      s_ready_o,
  input  logic      advance_i,
  output logic      valid_o,
  output afr_item_t item_o
);

  logic      valid_q, valid_d;
  logic      load;
  afr_item_t item_q;

  // The stage takes a new item when empty or when its item moves on.
  assign s_ready_o = !valid_q || advance_i;
  assign load      = s_valid_i && s_ready_o;
  assign valid_d   = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/afr_deframer.sv =====
// Frame parser: header capture, payload store, tick timeout and result build.
// Depends on afr_pkg for the phase and status codes and the shared structs.
module afr_deframer import afr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  afr_item_t   item_i,
  input  afr_cfg_t    cfg_i,
  output logic        result_valid_o,
  output afr_result_t result_o
);

  afr_phase_e       phase_q, phase_d;
  logic [ByteW-1:0] dest_q;
  logic [ByteW-1:0] source_q;
  logic [LenW-1:0]  length_q;
  logic [LenW-1:0]  index_q;
  logic [ByteW-1:0] tick_q;
  logic [ByteW-1:0] store_q [PayloadMax];

  logic             byte_in, tick_in;
  logic [LenW-1:0]  len_clamped, index_inc, len_now;
  logic [ByteW:0]   tick_next;
  logic [ByteW-1:0] limit;
  logic             frame_done, timed_out, accepted;

  // Event decode for the item leaving the input register.
  assign byte_in     = advance_i && (item_i.action == ACT_BYTE);
  assign tick_in     = advance_i && (item_i.action == ACT_TICK);
  assign len_clamped = (item_i.byte_value > ByteW'(PayloadMax)) ? LenMax
                                                                : item_i.byte_value[LenW-1:0];
  assign index_inc   = index_q + 1'b1;
  assign tick_next   = {1'b0, tick_q} + 1'b1;
  // A zero timeout register behaves as one.
  assign limit       = (cfg_i.timeout_ticks == '0) ? ByteW'(1) : cfg_i.timeout_ticks;

  assign frame_done = byte_in &&
                      (((phase_q == PH_LEN) && (len_clamped == '0)) ||
                       ((phase_q == PH_PAY) && (index_inc >= length_q)));
  assign timed_out  = tick_in && (phase_q != PH_IDLE) && (tick_next >= {1'b0, limit});
  assign accepted   = frame_done && (dest_q == cfg_i.own_address);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (frame_done || timed_out) begin
      phase_d = PH_IDLE;
    end else if (byte_in) begin
      case (phase_q)
        PH_IDLE: phase_d = PH_SRC;
        PH_SRC:  phase_d = PH_LEN;
        PH_LEN:  phase_d = PH_PAY;
        PH_PAY:  phase_d = PH_PAY;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Header holds, payload index and tick counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q   <= '0;
      source_q <= '0;
      length_q <= '0;
      index_q  <= '0;
      tick_q   <= '0;
    end else begin
      if (byte_in) begin
        tick_q <= '0;
        case (phase_q)
          PH_IDLE: dest_q <= item_i.byte_value;
          PH_SRC:  source_q <= item_i.byte_value;
          PH_LEN: begin
            length_q <= len_clamped;
            index_q  <= '0;
          end
          PH_PAY:  index_q <= frame_done ? '0 : index_inc;
          default: ;
        endcase
      end else if (tick_in && (phase_q != PH_IDLE)) begin
        if (timed_out) begin
          tick_q  <= '0;
          index_q <= '0;
        end else begin
          tick_q <= tick_next[ByteW-1:0];
        end
      end
    end
  end

  // Payload store; entries are only read below the length of the current frame.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PayloadMax; k++) begin
      if (byte_in && (phase_q == PH_PAY) && (index_q == LenW'(k))) begin
        store_q[k] <= item_i.byte_value;
      end
    end
  end

  // Result fields; the byte that completes a frame bypasses the store.
  assign len_now = (phase_q == PH_LEN) ? len_clamped : length_q;

  always_comb begin
    result_o.status  = ST_ACCEPTED;
    result_o.source  = '0;
    result_o.length  = '0;
    result_o.payload = '0;
    if (timed_out) begin
      result_o.status = (phase_q == PH_PAY) ? ST_PAY_TIMEOUT : ST_HDR_TIMEOUT;
    end else if (!accepted) begin
      result_o.status = ST_DROPPED;
    end else begin
      result_o.source = source_q;
      result_o.length = len_now;
      for (int k = 0; k < PayloadMax; k++) begin
        if (LenW'(k) < len_now) begin
          if ((phase_q == PH_PAY) && (index_q == LenW'(k))) begin
            result_o.payload[k] = item_i.byte_value;
          end else begin
            result_o.payload[k] = store_q[k];
          end
        end
      end
    end
  end

  assign result_valid_o = frame_done || timed_out;

endmodule

// ===== design/afr_out_reg.sv =====
// Result register driving the master-side stream.
// Depends on afr_pkg for the result struct and the output data width.
module afr_out_reg import afr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  afr_result_t         result_i,
  output logic                free_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o,
  output logic [1:0]          m_user_o
);

  localparam int unsigned PackW = ByteW + LenW + PayloadMax * ByteW;

  logic        valid_q, valid_d;
  afr_result_t result_q;

  // Room for a new result when empty or when the held one is taken now.
  assign free_o  = !valid_q || m_ready_i;
  assign valid_d = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  // Source in the low byte, then length, then the payload bytes in order.
  assign m_valid_o = valid_q;
  assign m_data_o  = {{(OutDataW - PackW){1'b0}},
                      result_q.payload, result_q.length, result_q.source};
  assign m_user_o  = result_q.status;

endmodule

// ===== design/addressed_frame_receiver_top.sv =====
// Top level of the addressed frame receiver.
// Depends on afr_pkg, the macro header and the afr_* submodules.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: received byte; tuser: 0 byte, 1 millisecond tick
//   m_axis    out        tdata: source, length, payload bytes; tuser: status
//   apb       in/out     timeout_ticks at 0x0, own_address at 0x4
//
// An item passes the input register and the result register; one item per cycle
// is sustained while the result stream is not stalled. The frame state update
// and result build sit in one short combinational step between the registers.
// Reset clears control state; the payload store holds no reset value.
// A stalled result blocks the input stage only once the input register is full.
`include "addressed_frame_receiver_top_macros.svh"
module addressed_frame_receiver_top import afr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] byte_value
  input  logic                s_axis_tuser,   // [0] action
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] source, [10:8] length,
                                              // [18:11] payload_0 .. [50:43] payload_4
  output logic [1:0]          m_axis_tuser,   // [1:0] status
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  afr_cfg_t    cfg;
  afr_item_t   s_item, item;
  logic        item_valid, advance, out_free;
  logic        result_valid;
  afr_result_t result;

  assign s_item.action     = afr_action_e'(s_axis_tuser);
  assign s_item.byte_value = s_axis_tdata;

  // An item leaves the input register when the result register has room.
  assign advance = item_valid && out_free;

  afr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  afr_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_item_i  (s_item),
    .s_ready_o (s_axis_tready),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  afr_deframer u_dfr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .item_i         (item),
    .cfg_i          (cfg),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  afr_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && result_valid),
    .result_i  (result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

  // Only accepted frames carry source, length and payload.
  `AFR_ASSERT_IMPL(a_zero_unless_accepted, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_ACCEPTED), m_axis_tdata == '0)
  // The reported length never exceeds the payload limit.
  `AFR_ASSERT_IMPL(a_length_limit, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[ByteW+LenW-1:ByteW] <= LenMax)
  // The input side stalls only behind a held, untaken result.
  `AFR_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // A produced result is presented in the following cycle.
  `AFR_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, advance && result_valid, m_axis_tvalid)

endmodule
